FILE: src/pump_run_timer_with_lockout_assert.svh
// ----------------------------------------------------------------------------
// pump run timer assertion macros
// shared property forms for the pump run timer checks
// ----------------------------------------------------------------------------
`ifndef PUMP_RUN_TIMER_WITH_LOCKOUT_ASSERT_SVH
`define PUMP_RUN_TIMER_WITH_LOCKOUT_ASSERT_SVH

// same-cycle implication, off during reset
`define PRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// types, constants and helpers shared by the pump run timer
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned SECS_W       = 16;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned MS_PER_S     = 1000;
  // width of secs * 1000, holds 65535 * 1000
  localparam int unsigned PROD_W       = 26;

  // register index bases
  localparam logic [CFG_IDX_W-1:0] CFG_ON_BASE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BASE = 4'd4;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_REQ_ON    = 2'd1,
    OP_FORCE_OFF = 2'd2,
    OP_TOGGLE    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [1:0]        channel;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] run_mask;
    logic              channel_running;
  } out_word_t;

  // now + secs * 1000, clamped at the top of the time range
  function automatic logic [TIME_W-1:0] add_secs_sat(input logic [TIME_W-1:0] now,
                                                     input logic [SECS_W-1:0] secs);
    logic [TIME_W:0] sum;
    sum = {1'b0, now} + (TIME_W+1)'(PROD_W'(secs) * PROD_W'(MS_PER_S));
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage

FILE: src/prt_time_mem.sv
// ----------------------------------------------------------------------------
// prt_time_mem
// per-channel time store, one write and one registered read port;
// entries never written since reset read as zero
// ----------------------------------------------------------------------------
module prt_time_mem
  import prt_pkg::*;
#(
  parameter int unsigned DEPTH = CHANNELS_DEF,
  parameter int unsigned AW    = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [TIME_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [TIME_W-1:0] rd_data_r;
  logic              rd_vld_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: src/pump_run_timer_with_lockout.sv
// ----------------------------------------------------------------------------
// pump_run_timer_with_lockout
// Sequence: a tick passes read, an exec step per channel and fin; request-on,
//   force-off or toggle pass read, exec and fin; a channel out of range goes
//   straight to fin. A new word is taken only in idle, after the result is
//   loaded; the tick walks the deadline store one channel per cycle.
// Reset: synchronous active low; pumps off, times and registers read zero.
// ----------------------------------------------------------------------------
module pump_run_timer_with_lockout
  import prt_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SECS_W-1:0]    cfg_wdata
);

  `include "pump_run_timer_with_lockout_assert.svh"

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

  state_t            state_r, state_nxt;
  opcode_t           op_r;
  logic [1:0]        ch_r;
  logic              ch_ok_r;
  logic [TIME_W-1:0] now_r;
  logic [CH_W-1:0]   idx_r, idx_nxt;
  logic [CHANNELS-1:0] running_r, running_nxt;
  logic [SECS_W-1:0] on_sec_r  [CHANNELS];
  logic [SECS_W-1:0] off_sec_r [CHANNELS];
  logic              out_valid_r;
  out_word_t         out_word_r;

  logic              in_acc;
  logic              in_ch_ok;
  logic              out_load;
  logic              dl_we, dl_re, ra_we, ra_re;
  logic [CH_W-1:0]   dl_waddr, dl_raddr, ra_waddr, ra_raddr;
  logic [TIME_W-1:0] dl_wdata, ra_wdata, dl_rdata, ra_rdata;

  // deadline and lockout stores
  prt_time_mem #(.DEPTH(CHANNELS), .AW(CH_W)) u_deadline (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (dl_we),
    .wr_addr (dl_waddr),
    .wr_data (dl_wdata),
    .rd_en   (dl_re),
    .rd_addr (dl_raddr),
    .rd_data (dl_rdata)
  );

  prt_time_mem #(.DEPTH(CHANNELS), .AW(CH_W)) u_lockout (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ra_we),
    .wr_addr (ra_waddr),
    .wr_data (ra_wdata),
    .rd_en   (ra_re),
    .rd_addr (ra_raddr),
    .rd_data (ra_rdata)
  );

  // no word is taken while in reset or busy
  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign in_acc   = in_valid && !in_stall;
  assign in_ch_ok = ({1'b0, in_word.channel} < 3'(CHANNELS));
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_sec_r[i]  <= '0;
        off_sec_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index >= CFG_ON_BASE && cfg_index < CFG_ON_BASE + CFG_IDX_W'(CHANNELS)) begin
        on_sec_r[cfg_index[CH_W-1:0]] <= cfg_wdata;
      end else if (cfg_index >= CFG_OFF_BASE &&
                   cfg_index < CFG_OFF_BASE + CFG_IDX_W'(CHANNELS)) begin
        off_sec_r[cfg_index[CH_W-1:0]] <= cfg_wdata;
      end
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_word.opcode;
      ch_r    <= in_word.channel;
      ch_ok_r <= in_ch_ok;
      now_r   <= in_word.now_ms;
    end
  end

  // sequencer and run flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      idx_r     <= '0;
      running_r <= '0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      running_r <= running_nxt;
    end
  end

  // next state, store accesses and run flag updates
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    running_nxt = running_r;
    dl_we       = 1'b0;
    dl_waddr    = idx_r;
    dl_wdata    = add_secs_sat(now_r, on_sec_r[idx_r]);
    dl_re       = 1'b0;
    dl_raddr    = idx_r;
    ra_we       = 1'b0;
    ra_waddr    = idx_r;
    ra_wdata    = add_secs_sat(now_r, off_sec_r[idx_r]);
    ra_re       = 1'b0;
    ra_raddr    = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.opcode == OP_TICK) begin
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end else if (in_ch_ok) begin
            idx_nxt   = in_word.channel[CH_W-1:0];
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_READ: begin
        dl_re     = 1'b1;
        ra_re     = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_TICK: begin
            // switch off when the deadline has strictly passed
            if (running_r[idx_r] && now_r > dl_rdata) begin
              running_nxt[idx_r] = 1'b0;
              ra_we              = 1'b1;
            end
            if (idx_r == LAST_CH) begin
              state_nxt = ST_FIN;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              dl_re     = 1'b1;
              dl_raddr  = idx_r + 1'b1;
            end
          end
          OP_REQ_ON: begin
            if (!running_r[idx_r] && now_r > ra_rdata) begin
              running_nxt[idx_r] = 1'b1;
              dl_we              = 1'b1;
            end
            state_nxt = ST_FIN;
          end
          OP_FORCE_OFF: begin
            running_nxt[idx_r] = 1'b0;
            ra_we              = 1'b1;
            state_nxt          = ST_FIN;
          end
          OP_TOGGLE: begin
            running_nxt[idx_r] = !running_r[idx_r];
            state_nxt          = ST_FIN;
          end
          default: begin
            state_nxt = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.run_mask        <= MASK_W'(running_r);
      out_word_r.channel_running <= (op_r != OP_TICK) && ch_ok_r &&
                                    running_r[ch_r[CH_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // checks
  `PRT_ASSERT_NEXT(a_accept_starts_work, in_valid && !in_stall,
                   state_r == ST_READ || state_r == ST_FIN,
                   "accepted word did not start work")
  `PRT_ASSERT_NEXT(a_fin_loads_result, out_load, out_valid_r, "finished word not shown")
  `PRT_ASSERT_NEXT(a_tick_never_starts, state_r == ST_EXEC && op_r == OP_TICK,
                   (running_r & ~$past(running_r)) == '0, "tick started a pump")
  `PRT_ASSERT_SAME(a_mask_in_range, out_valid, (out_word.run_mask >> CHANNELS) == '0,
                   "run mask beyond channel count")

endmodule
